@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

@@ src/srsm_pkg.sv @@
// ----------------------------------------------------------------------------
// srsm_pkg
// Types, character codes and helpers for the stream regex matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package srsm_pkg;

   localparam int MAX_ELEMENTS_DEF = 32;
   localparam int SYMBOL_W         = 8;
   localparam int KIND_W           = 2;

   localparam logic [SYMBOL_W-1:0] CHAR_CARET  = 8'h5E;  // '^'
   localparam logic [SYMBOL_W-1:0] CHAR_DOLLAR = 8'h24;  // '$'
   localparam logic [SYMBOL_W-1:0] CHAR_STAR   = 8'h2A;  // '*'
   localparam logic [SYMBOL_W-1:0] CHAR_DOT    = 8'h2E;  // '.'
   localparam logic [SYMBOL_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [SYMBOL_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [SYMBOL_W-1:0] CASE_OFFSET  = 8'h20;

   typedef enum logic [KIND_W-1:0] {
      KIND_PATTERN = 2'd0,
      KIND_TEXT    = 2'd1,
      KIND_END     = 2'd2
   } kind_type;

   // Fold ASCII upper case to lower when case folding is on.
   function automatic logic [SYMBOL_W-1:0] fold_char(input logic [SYMBOL_W-1:0] c,
                                                     input logic ci);
      if (ci && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         return c + CASE_OFFSET;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ src/srsm_if.sv @@
// ----------------------------------------------------------------------------
// srsm_req_if / srsm_rsp_if
// Valid/ready channels for request words and match response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface srsm_req_if
   import srsm_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [SYMBOL_W-1:0] symbol;
   logic                new_pattern;

   modport source (output valid, output kind, output symbol, output new_pattern,
                   input ready);
   modport sink   (input valid, input kind, input symbol, input new_pattern,
                   output ready);
endinterface

interface srsm_rsp_if;
   logic valid;
   logic ready;
   logic matched;
   logic pattern_overflow;

   modport source (output valid, output matched, output pattern_overflow,
                   input ready);
   modport sink   (input valid, input matched, input pattern_overflow,
                   output ready);
endinterface

`default_nettype wire

@@ src/simple_regex_stream_match.sv @@
// ----------------------------------------------------------------------------
// simple_regex_stream_match
// Streaming matcher for simple regular expressions over a bit-vector NFA.
// ----------------------------------------------------------------------------
// Takes one word per cycle while not stalled. A word is latched into an input register, and
// in the next cycle a single combinational pass updates the pattern store or
// the NFA position vector (star closure by a log-depth prefix network); an
// end-of-text word loads the response register when it leaves the input
// register, and the response is held there until it is taken. The input
// side keeps accepting while a response waits; it stalls only when an
// end-of-text word meets a full response register that is not being taken.
// Pattern words load literals, '.', '*', a leading '^' and a trailing '$';
// more than MAX_ELEMENTS elements flags pattern_overflow. No clearing pass
// is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module simple_regex_stream_match
   import srsm_pkg::*;
#(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    csr_wr_en,
   input  wire logic    csr_wr_data,
   srsm_req_if.sink     req_bus,
   srsm_rsp_if.source   rsp_bus
);

`include "assert_macros.svh"

   localparam int CW     = $clog2(MAX_ELEMENTS + 1);
   localparam int IW     = $clog2(MAX_ELEMENTS);
   localparam int LEVELS = $clog2(MAX_ELEMENTS + 1);

   // Forward star closure: out[i+1] |= out[i] & p[i], as a prefix network.
   function automatic logic [MAX_ELEMENTS:0] close_over(input logic [MAX_ELEMENTS:0] s,
                                                        input logic [MAX_ELEMENTS-1:0] p);
      logic [MAX_ELEMENTS:0] g;
      logic [MAX_ELEMENTS:0] pr;
      logic [MAX_ELEMENTS:0] g_n;
      logic [MAX_ELEMENTS:0] pr_n;
      g  = s;
      pr = {p, 1'b0};
      for (int lv = 0; lv < LEVELS; lv++) begin
         g_n  = g;
         pr_n = pr;
         for (int i = 0; i <= MAX_ELEMENTS; i++) begin
            if (i >= (1 << lv)) begin
               g_n[i]  = g[i] | (pr[i] & g[i - (1 << lv)]);
               pr_n[i] = pr[i] & pr[i - (1 << lv)];
            end
         end
         g  = g_n;
         pr = pr_n;
      end
      return g;
   endfunction

   // Input register
   logic                s1_valid_ff, s1_valid_in;
   logic [KIND_W-1:0]   s1_kind_ff;
   logic [SYMBOL_W-1:0] s1_symbol_ff;
   logic                s1_new_ff;
   logic                s1_fire;
   logic                s1_is_end;

   // Pattern store
   logic [SYMBOL_W-1:0] char_ff [MAX_ELEMENTS];
   logic                star_ff [MAX_ELEMENTS];
   logic [CW-1:0]       count_ff, count_in;
   logic                anchored_ff, anchored_in;
   logic                ovf_ff, ovf_in;
   logic                last_dollar_ff, last_dollar_in;
   logic                last_star_ff, last_star_in;
   logic                char_we;
   logic [IW-1:0]       char_addr;
   logic                star_we;
   logic [IW-1:0]       star_addr;

   // Text state
   logic [MAX_ELEMENTS:0] active_ff, active_in;
   logic                  seen_ff, seen_in;
   logic                  text_ff, text_in;
   logic                  ci_ff;

   // Response register
   logic rsp_valid_ff, rsp_valid_in;
   logic matched_ff, matched_in;
   logic rsp_ovf_ff, rsp_ovf_in;

   // Datapath
   logic                  end_anch;
   logic [CW-1:0]         live_n;
   logic [CW-1:0]         count_m1;
   logic [MAX_ELEMENTS-1:0] star_eff;
   logic [MAX_ELEMENTS-1:0] lane_hit;
   logic [MAX_ELEMENTS:0] start_vec;
   logic [MAX_ELEMENTS:0] base_vec;
   logic                  base_seen;
   logic [MAX_ELEMENTS:0] raw_vec;
   logic [MAX_ELEMENTS:0] next_vec;
   logic [SYMBOL_W-1:0]   text_char;
   logic [CW-1:0]         p_count;
   logic                  p_anch;
   logic                  p_ovf;

   assign s1_is_end = (s1_kind_ff == KIND_END);
   assign s1_fire   = s1_valid_ff && (!s1_is_end || !rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_fire;

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.matched          = matched_ff;
   assign rsp_bus.pattern_overflow = rsp_ovf_ff;

   assign end_anch = (count_ff != '0) && last_dollar_ff && !last_star_ff;
   assign live_n   = count_ff - CW'(end_anch);
   assign count_m1 = count_ff - CW'(1);
   assign text_char = fold_char(s1_symbol_ff, ci_ff);

   always_comb begin
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
         star_eff[i] = star_ff[i] && (CW'(i) < live_n);
         lane_hit[i] = (CW'(i) < live_n) &&
                       ((char_ff[i] == CHAR_DOT) || (fold_char(char_ff[i], ci_ff) == text_char));
      end
   end

   assign start_vec = close_over({{MAX_ELEMENTS{1'b0}}, 1'b1}, star_eff);
   assign base_vec  = text_ff ? active_ff : start_vec;
   assign base_seen = text_ff ? seen_ff : start_vec[live_n];

   // One NFA step: a starred lane stays put, a plain lane advances.
   always_comb begin
      raw_vec = '0;
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
         if (base_vec[i] && lane_hit[i]) begin
            if (star_ff[i]) begin
               raw_vec[i] = 1'b1;
            end else begin
               raw_vec[i + 1] = 1'b1;
            end
         end
      end
      if (!anchored_ff) begin
         raw_vec[0] = 1'b1;
      end
   end

   assign next_vec = close_over(raw_vec, star_eff);

   // Next state
   always_comb begin
      s1_valid_in    = s1_valid_ff;
      count_in       = count_ff;
      anchored_in    = anchored_ff;
      ovf_in         = ovf_ff;
      last_dollar_in = last_dollar_ff;
      last_star_in   = last_star_ff;
      active_in      = active_ff;
      seen_in        = seen_ff;
      text_in        = text_ff;
      char_we        = 1'b0;
      char_addr      = count_ff[IW-1:0];
      star_we        = 1'b0;
      star_addr      = count_m1[IW-1:0];
      rsp_valid_in   = rsp_valid_ff;
      matched_in     = matched_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      p_count        = s1_new_ff ? '0 : count_ff;
      p_anch         = s1_new_ff ? 1'b0 : anchored_ff;
      p_ovf          = s1_new_ff ? 1'b0 : ovf_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (s1_fire) begin
         s1_valid_in = 1'b0;
         case (s1_kind_ff)
            KIND_PATTERN: begin
               count_in    = p_count;
               anchored_in = p_anch;
               ovf_in      = p_ovf;
               active_in   = '0;
               seen_in     = 1'b0;
               text_in     = 1'b0;
               if (!p_ovf) begin
                  if (s1_symbol_ff == CHAR_CARET && p_count == '0 && !p_anch) begin
                     anchored_in = 1'b1;
                  end else if (s1_symbol_ff == CHAR_STAR && p_count != '0 &&
                               !last_star_ff) begin
                     star_we      = 1'b1;
                     last_star_in = 1'b1;
                  end else if (p_count >= CW'(MAX_ELEMENTS)) begin
                     ovf_in = 1'b1;
                  end else begin
                     char_we        = 1'b1;
                     char_addr      = p_count[IW-1:0];
                     count_in       = p_count + CW'(1);
                     last_dollar_in = (s1_symbol_ff == CHAR_DOLLAR);
                     last_star_in   = 1'b0;
                  end
               end
            end
            KIND_TEXT: begin
               active_in = next_vec;
               seen_in   = base_seen || next_vec[live_n];
               text_in   = 1'b1;
            end
            KIND_END: begin
               rsp_valid_in = 1'b1;
               matched_in   = !ovf_ff && (end_anch ? base_vec[live_n] : base_seen);
               rsp_ovf_in   = ovf_ff;
               active_in    = '0;
               seen_in      = 1'b0;
               text_in      = 1'b0;
            end
            default: begin
               // unused kind: drop the word
            end
         endcase
      end

      if (req_bus.valid && req_bus.ready) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         count_ff       <= '0;
         anchored_ff    <= 1'b0;
         ovf_ff         <= 1'b0;
         last_dollar_ff <= 1'b0;
         last_star_ff   <= 1'b0;
         active_ff      <= '0;
         seen_ff        <= 1'b0;
         text_ff        <= 1'b0;
         ci_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         count_ff       <= count_in;
         anchored_ff    <= anchored_in;
         ovf_ff         <= ovf_in;
         last_dollar_ff <= last_dollar_in;
         last_star_ff   <= last_star_in;
         active_ff      <= active_in;
         seen_ff        <= seen_in;
         text_ff        <= text_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) begin
            ci_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_kind_ff   <= req_bus.kind;
         s1_symbol_ff <= req_bus.symbol;
         s1_new_ff    <= req_bus.new_pattern;
      end
      matched_ff <= matched_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   // Element store: one write port, every lane read in place.
   always_ff @(posedge clock) begin
      if (char_we) begin
         char_ff[char_addr] <= s1_symbol_ff;
         star_ff[char_addr] <= 1'b0;
      end
      if (star_we) begin
         star_ff[star_addr] <= 1'b1;
      end
   end

   `ASSERT_NOW(a_end_waits_for_slot, clock, reset, s1_fire && s1_is_end, !rsp_valid_ff || rsp_bus.ready)
   `ASSERT_NOW(a_ovf_never_matches, clock, reset, rsp_valid_ff, !(matched_ff && rsp_ovf_ff))
   `ASSERT_NOW(a_count_in_range, clock, reset, 1'b1, count_ff <= CW'(MAX_ELEMENTS))
   `ASSERT_NEXT(a_end_clears_text, clock, reset, s1_fire && s1_is_end, !text_ff && !seen_ff)

endmodule

`default_nettype wire

@@ sim/simple_regex_stream_match_tb.sv @@
// ----------------------------------------------------------------------------
// simple_regex_stream_match_tb
// Self-checking bench for the stream regex matcher: pattern and text words
// go in over the request channel, and a scoreboard that tracks the element
// list and the NFA positions predicts each end-of-text response. Directed
// anchor, star and abort cases come first, then random pattern/text
// sequences under three idle profiles and both case-fold settings, with one
// long response back-pressure stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module simple_regex_stream_match_tb
   import srsm_pkg::*;
   ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_EL      = MAX_ELEMENTS_DEF;
   localparam int PHASE_WORDS = 200;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE      = 6;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef logic [MAX_EL:0] pos_vec_type;

   typedef struct packed {
      logic matched;
      logic pattern_overflow;
   } match_result_type;

   class match_scoreboard;
      bit                  fold_on;
      logic [SYMBOL_W-1:0] elem_char [MAX_EL];
      bit                  elem_star [MAX_EL];
      int unsigned         n_elems;
      bit                  anchored_start;
      bit                  overflow_seen;
      pos_vec_type         pos;
      bit                  any_accept;
      bit                  text_open;
      match_result_type    expected_results[$];
      int                  errors;

      function logic [SYMBOL_W-1:0] fold(logic [SYMBOL_W-1:0] c);
         if (fold_on && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            return c + CASE_OFFSET;
         end
         return c;
      endfunction

      function bit ends_anchored();
         return n_elems > 0 && elem_char[n_elems-1] == CHAR_DOLLAR && !elem_star[n_elems-1];
      endfunction

      function int unsigned live_len();
         return ends_anchored() ? n_elems - 1 : n_elems;
      endfunction

      // Starred positions may be skipped, so carry them forward in one pass.
      function pos_vec_type close_stars(pos_vec_type v, int unsigned n);
         for (int i = 0; i < n; i++) begin
            if (v[i] && elem_star[i]) begin
               v[i+1] = 1'b1;
            end
         end
         return v;
      endfunction

      function void clear_text();
         pos        = '0;
         any_accept = 1'b0;
         text_open  = 1'b0;
      endfunction

      function void open_text(int unsigned n);
         pos        = close_stars(pos_vec_type'(1), n);
         any_accept = pos[n];
         text_open  = 1'b1;
      endfunction

      function void take_pattern(logic [SYMBOL_W-1:0] c, logic fresh);
         if (fresh) begin
            n_elems        = 0;
            anchored_start = 1'b0;
            overflow_seen  = 1'b0;
         end
         clear_text();
         if (overflow_seen) begin
            return;
         end
         if (c == CHAR_CARET && n_elems == 0 && !anchored_start) begin
            anchored_start = 1'b1;
         end else if (c == CHAR_STAR && n_elems > 0 && !elem_star[n_elems-1]) begin
            elem_star[n_elems-1] = 1'b1;
         end else if (n_elems >= MAX_EL) begin
            overflow_seen = 1'b1;
         end else begin
            elem_char[n_elems] = c;
            elem_star[n_elems] = 1'b0;
            n_elems++;
         end
      endfunction

      function void take_text(logic [SYMBOL_W-1:0] c);
         pos_vec_type         nxt;
         int unsigned         n;
         logic [SYMBOL_W-1:0] t;
         n = live_len();
         t = fold(c);
         if (!text_open) begin
            open_text(n);
         end
         nxt = '0;
         for (int i = 0; i < n; i++) begin
            if (pos[i] && (elem_char[i] == CHAR_DOT || fold(elem_char[i]) == t)) begin
               if (elem_star[i]) begin
                  nxt[i] = 1'b1;
               end else begin
                  nxt[i+1] = 1'b1;
               end
            end
         end
         if (!anchored_start) begin
            nxt[0] = 1'b1;
         end
         pos = close_stars(nxt, n);
         if (pos[n]) begin
            any_accept = 1'b1;
         end
      endfunction

      function void take_end();
         int unsigned      n;
         bit               hit;
         match_result_type r;
         n = live_len();
         if (!text_open) begin
            open_text(n);
         end
         hit                = ends_anchored() ? pos[n] : any_accept;
         r.matched          = !overflow_seen && hit;
         r.pattern_overflow = overflow_seen;
         expected_results.push_back(r);
         clear_text();
      endfunction

      // Note one accepted request word.
      function void note_word(logic [KIND_W-1:0] k, logic [SYMBOL_W-1:0] s, logic np);
         case (k)
            KIND_PATTERN: take_pattern(s, np);
            KIND_TEXT:    take_text(s);
            KIND_END:     take_end();
            default:      ;
         endcase
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("[%0t] mismatch: %s", $realtime, what);
      endtask

      task check_result(logic m, logic o);
         match_result_type e;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("response matched=%b overflow=%b with none pending", m, o));
         end else begin
            e = expected_results.pop_front();
            if (m !== e.matched || o !== e.pattern_overflow) begin
               report_mismatch($sformatf("matched %b (want %b) overflow %b (want %b)",
                                         m, e.matched, o, e.pattern_overflow));
            end
         end
      endtask

      task drain_check();
         if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d responses never arrived", expected_results.size()));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   srsm_req_if req_bus ();
   srsm_rsp_if rsp_bus ();

   simple_regex_stream_match uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   match_scoreboard sb = new();

   int send_idle_pct;
   int recv_idle_pct;
   int words_taken;
   bit hold_request;
   int cycles;

   always #10 clock = ~clock;

   // Response side: random ready, or a long hold-off when requested.
   initial begin
      int hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sb.check_result(rsp_bus.matched, rsp_bus.pattern_overflow);
      end
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Offer one word; return at the falling edge after it is taken.
   task automatic send_word(logic [KIND_W-1:0] k, logic [SYMBOL_W-1:0] s, logic np);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.kind        <= k;
      req_bus.symbol      <= s;
      req_bus.new_pattern <= np;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      sb.note_word(k, s, np);
      if (k != KIND_UNUSED) begin
         words_taken++;
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (sb.expected_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_case_fold(bit v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.fold_on = v;
   endtask

   function automatic logic [SYMBOL_W-1:0] pattern_char();
      string specials = "^*$.";
      string letters  = "aAbB";
      int    r;
      r = $urandom_range(99);
      if (r < 25) begin
         return specials[$urandom_range(3)];
      end else if (r < 80) begin
         return letters[$urandom_range(3)];
      end
      return SYMBOL_W'($urandom_range(255));
   endfunction

   function automatic logic [SYMBOL_W-1:0] text_char();
      string letters  = "aAbB";
      string specials = "$^*.";
      int    r;
      r = $urandom_range(99);
      if (r < 70) begin
         return letters[$urandom_range(3)];
      end else if (r < 80) begin
         return specials[$urandom_range(3)];
      end
      return SYMBOL_W'($urandom_range(255));
   endfunction

   task automatic send_texts(int count);
      repeat (count) begin
         repeat ($urandom_range(8)) send_word(KIND_TEXT, text_char(), 1'($urandom_range(1)));
         send_word(KIND_END, SYMBOL_W'($urandom_range(255)), 1'($urandom_range(1)));
      end
   endtask

   task automatic run_random(int target);
      int start;
      int r;
      start = words_taken;
      while (words_taken - start < target) begin
         r = $urandom_range(99);
         if (r < 72) begin
            // Well-formed: optional fresh pattern, then a few texts.
            if ($urandom_range(99) < 55) begin
               send_word(KIND_PATTERN,
                         ($urandom_range(99) < 30) ? CHAR_CARET : pattern_char(), 1'b1);
               repeat ($urandom_range(6)) send_word(KIND_PATTERN, pattern_char(), 1'b0);
            end
            send_texts($urandom_range(1, 3));
         end else if (r < 77) begin
            // Long pattern around the element capacity.
            send_word(KIND_PATTERN, "a", 1'b1);
            repeat ($urandom_range(MAX_EL - 2, MAX_EL + 6)) begin
               send_word(KIND_PATTERN, "b", 1'b0);
            end
            repeat ($urandom_range(2)) send_word(KIND_PATTERN, pattern_char(), 1'b0);
            send_texts(1);
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_word(KIND_W'($urandom_range(3)), SYMBOL_W'($urandom_range(255)),
                         1'($urandom_range(1)));
            end
         end
      end
   endtask

   initial begin
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = 1'b0;
      req_bus.valid       = 1'b0;
      req_bus.kind        = KIND_PATTERN;
      req_bus.symbol      = '0;
      req_bus.new_pattern = 1'b0;
      hold_request        = 1'b0;
      words_taken         = 0;
      send_idle_pct       = 10;
      recv_idle_pct       = 58;
      sb.clear_text();
      sb.n_elems        = 0;
      sb.anchored_start = 1'b0;
      sb.overflow_seen  = 1'b0;
      sb.fold_on        = 1'b0;
      sb.errors         = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_case_fold(1'b0);

      // Empty pattern, empty text.
      send_word(KIND_END, 8'h00, 1'b0);
      // Anchored both ends with a starred literal.
      send_word(KIND_PATTERN, CHAR_CARET, 1'b1);
      send_word(KIND_PATTERN, "a", 1'b0);
      send_word(KIND_PATTERN, CHAR_STAR, 1'b0);
      send_word(KIND_PATTERN, CHAR_DOLLAR, 1'b0);
      send_word(KIND_TEXT, "a", 1'b0);
      send_word(KIND_TEXT, "a", 1'b0);
      send_word(KIND_END, 8'hFF, 1'b1);
      send_word(KIND_END, 8'h00, 1'b0);
      send_word(KIND_TEXT, "b", 1'b0);
      send_word(KIND_END, 8'h00, 1'b0);
      // Star on a starred element and a late caret are literals.
      send_word(KIND_PATTERN, "a", 1'b1);
      send_word(KIND_PATTERN, CHAR_STAR, 1'b0);
      send_word(KIND_PATTERN, CHAR_STAR, 1'b0);
      send_word(KIND_PATTERN, CHAR_CARET, 1'b0);
      send_word(KIND_TEXT, CHAR_STAR, 1'b0);
      send_word(KIND_TEXT, CHAR_CARET, 1'b0);
      send_word(KIND_END, 8'h00, 1'b0);
      // Zero symbol on both sides, then abort the text with a pattern word.
      send_word(KIND_PATTERN, 8'h00, 1'b1);
      send_word(KIND_TEXT, 8'h00, 1'b0);
      send_word(KIND_PATTERN, CHAR_DOLLAR, 1'b0);
      send_word(KIND_END, 8'h00, 1'b0);
      // Leading star literal, starred dollar, unused kind.
      send_word(KIND_PATTERN, CHAR_STAR, 1'b1);
      send_word(KIND_PATTERN, CHAR_DOLLAR, 1'b0);
      send_word(KIND_PATTERN, CHAR_STAR, 1'b0);
      send_word(KIND_UNUSED, 8'hFF, 1'b1);
      send_word(KIND_TEXT, CHAR_STAR, 1'b0);
      send_word(KIND_END, 8'h00, 1'b0);
      wait_drained();

      write_case_fold(1'b1);
      run_random(PHASE_WORDS);
      wait_drained();

      send_idle_pct = 58;
      recv_idle_pct = 10;
      write_case_fold(1'b0);
      run_random(PHASE_WORDS);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_case_fold(1'b1);
      hold_request = 1'b1;
      run_random(PHASE_WORDS);
      wait_drained();

      sb.drain_check();
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire
